// File: sv/avccrp_pkg.sv
package avccrp_pkg;

  // Parse phases of the configuration record.
  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_SPSCOUNT = 4'd1,
    PH_SPSHI    = 4'd2,
    PH_SPSLO    = 4'd3,
    PH_SPSPAY   = 4'd4,
    PH_PPSCOUNT = 4'd5,
    PH_PPSHI    = 4'd6,
    PH_PPSLO    = 4'd7,
    PH_PPSPAY   = 4'd8,
    PH_DONE     = 4'd9
  } phase_e;

  // Role tag carried with every byte.
  typedef enum logic [2:0] {
    ROLE_HEADER   = 3'd0,
    ROLE_SPSCOUNT = 3'd1,
    ROLE_LENGTH   = 3'd2,
    ROLE_PPSCOUNT = 3'd3,
    ROLE_SPSPAY   = 3'd4,
    ROLE_PPSPAY   = 3'd5,
    ROLE_TRAILING = 3'd6
  } role_e;

  // Record status reported on the final byte.
  localparam logic STATUS_COMPLETE  = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  // Index of the last header byte (the one carrying the length size).
  localparam logic [2:0] HeaderLastPos = 3'd4;

  // The SPS count occupies the low five bits of its byte.
  localparam logic [7:0] SpsCountMask = 8'h1F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [2:0] role;
    logic [7:0] set_index;
    logic       set_end;
    logic       record_done;
    logic       status;
    logic [7:0] version;
    logic [7:0] profile;
    logic [7:0] compatibility;
    logic [7:0] level;
    logic [1:0] length_size_minus_one;
  } out_t;

endpackage

// File: sv/avc_config_record_parser.sv
// AVC decoder configuration record parser. Record bytes enter one per
// transaction on the input channel, with last_byte set on the final byte of
// the buffer; each byte is registered and leaves on the output channel, tagged
// with its role, its parameter set index and an end-of-set mark, together
// with the header values captured so far. The block takes one byte every
// clock cycle while the output channel is not stalling it: all parse logic
// sits between the parse state registers and a single output register, and
// a new transaction is accepted whenever that output register is empty or
// is being drained in the same cycle. On the final byte the status field
// reports a complete or truncated record and the parser rearms for the next
// record; captured header values persist until overwritten by the next record.
module avc_config_record_parser
  import avccrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  sets_left_q, sets_left_d;
  logic [7:0]  cur_set_q, cur_set_d;
  logic [7:0]  len_high_q, len_high_d;
  logic [15:0] pay_left_q, pay_left_d;

  // Captured header values.
  logic [7:0]  version_q, version_d;
  logic [7:0]  profile_q, profile_d;
  logic [7:0]  compat_q, compat_d;
  logic [7:0]  level_q, level_d;
  logic [1:0]  len_size_q, len_size_d;

  // Output register.
  logic        out_valid_q;
  out_t        out_q, out_d;

  logic        in_accept;
  logic [7:0]  b;
  logic [2:0]  role;
  logic [7:0]  idx;
  logic        send;
  logic [7:0]  sets_dec;
  logic [15:0] pay_dec;
  logic [15:0] pay_new;
  phase_e      phase_upd;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign b        = in_data_i.data_byte;
  assign sets_dec = sets_left_q - 8'd1;
  assign pay_dec  = pay_left_q - 16'd1;
  assign pay_new  = {len_high_q, b};

  // Per-byte parse step: role tagging and next parse state.
  always_comb begin
    phase_upd  = phase_q;
    hdr_pos_d  = hdr_pos_q;
    sets_left_d = sets_left_q;
    cur_set_d  = cur_set_q;
    len_high_d = len_high_q;
    pay_left_d = pay_left_q;
    version_d  = version_q;
    profile_d  = profile_q;
    compat_d   = compat_q;
    level_d    = level_q;
    len_size_d = len_size_q;
    role       = ROLE_TRAILING;
    idx        = 8'd0;
    send       = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        role = ROLE_HEADER;
        case (hdr_pos_q)
          3'd0:    version_d  = b;
          3'd1:    profile_d  = b;
          3'd2:    compat_d   = b;
          3'd3:    level_d    = b;
          default: len_size_d = b[1:0];
        endcase
        if (hdr_pos_q >= HeaderLastPos) begin
          hdr_pos_d = 3'd0;
          phase_upd = PH_SPSCOUNT;
        end else begin
          hdr_pos_d = hdr_pos_q + 3'd1;
        end
      end
      PH_SPSCOUNT: begin
        role        = ROLE_SPSCOUNT;
        sets_left_d = b & SpsCountMask;
        cur_set_d   = 8'd0;
        phase_upd   = ((b & SpsCountMask) == 8'd0) ? PH_PPSCOUNT : PH_SPSHI;
      end
      PH_PPSCOUNT: begin
        role        = ROLE_PPSCOUNT;
        sets_left_d = b;
        cur_set_d   = 8'd0;
        phase_upd   = (b == 8'd0) ? PH_DONE : PH_PPSHI;
      end
      PH_SPSHI, PH_PPSHI: begin
        role       = ROLE_LENGTH;
        idx        = cur_set_q;
        len_high_d = b;
        phase_upd  = (phase_q == PH_PPSHI) ? PH_PPSLO : PH_SPSLO;
      end
      PH_SPSLO, PH_PPSLO: begin
        role       = ROLE_LENGTH;
        idx        = cur_set_q;
        pay_left_d = pay_new;
        if (pay_new == 16'd0) begin
          // Empty set: it ends on its low length byte.
          send        = 1'b1;
          sets_left_d = sets_dec;
          cur_set_d   = cur_set_q + 8'd1;
          if (sets_dec == 8'd0) begin
            phase_upd = (phase_q == PH_PPSLO) ? PH_DONE : PH_PPSCOUNT;
          end else begin
            phase_upd = (phase_q == PH_PPSLO) ? PH_PPSHI : PH_SPSHI;
          end
        end else begin
          phase_upd = (phase_q == PH_PPSLO) ? PH_PPSPAY : PH_SPSPAY;
        end
      end
      PH_SPSPAY, PH_PPSPAY: begin
        role       = (phase_q == PH_PPSPAY) ? ROLE_PPSPAY : ROLE_SPSPAY;
        idx        = cur_set_q;
        pay_left_d = pay_dec;
        if (pay_dec == 16'd0) begin
          send        = 1'b1;
          sets_left_d = sets_dec;
          cur_set_d   = cur_set_q + 8'd1;
          if (sets_dec == 8'd0) begin
            phase_upd = (phase_q == PH_PPSPAY) ? PH_DONE : PH_PPSCOUNT;
          end else begin
            phase_upd = (phase_q == PH_PPSPAY) ? PH_PPSHI : PH_SPSHI;
          end
        end
      end
      default: begin
        // Complete record or an unused code: trailing bytes are ignored.
        role = ROLE_TRAILING;
      end
    endcase
  end

  // Result assembly and rearm on the final byte.
  always_comb begin
    out_d.byte_value            = b;
    out_d.role                  = role;
    out_d.set_index             = idx;
    out_d.set_end               = send;
    out_d.record_done           = in_data_i.last_byte;
    out_d.status                = (in_data_i.last_byte && (phase_upd < PH_DONE)) ?
                                  STATUS_TRUNCATED : STATUS_COMPLETE;
    out_d.version               = version_d;
    out_d.profile               = profile_d;
    out_d.compatibility         = compat_d;
    out_d.level                 = level_d;
    out_d.length_size_minus_one = len_size_d;
    phase_d                     = in_data_i.last_byte ? PH_HEADER : phase_upd;
  end

  // Parse state and header registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_pos_q   <= 3'd0;
      sets_left_q <= 8'd0;
      cur_set_q   <= 8'd0;
      len_high_q  <= 8'd0;
      pay_left_q  <= 16'd0;
      version_q   <= 8'd0;
      profile_q   <= 8'd0;
      compat_q    <= 8'd0;
      level_q     <= 8'd0;
      len_size_q  <= 2'd0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      version_q  <= version_d;
      profile_q  <= profile_d;
      compat_q   <= compat_d;
      level_q    <= level_d;
      len_size_q <= len_size_d;
      if (in_data_i.last_byte) begin
        hdr_pos_q   <= 3'd0;
        sets_left_q <= 8'd0;
        cur_set_q   <= 8'd0;
        len_high_q  <= 8'd0;
        pay_left_q  <= 16'd0;
      end else begin
        hdr_pos_q   <= hdr_pos_d;
        sets_left_q <= sets_left_d;
        cur_set_q   <= cur_set_d;
        len_high_q  <= len_high_d;
        pay_left_q  <= pay_left_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // A final byte always rearms the parser.
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last_byte |=> phase_q == PH_HEADER && hdr_pos_q == 3'd0)
    else $error("parser did not rearm after the final byte");

  // A payload phase always has bytes outstanding.
  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SPSPAY || phase_q == PH_PPSPAY) |-> pay_left_q != 16'd0)
    else $error("payload phase entered with no bytes left");

  // Length and payload phases always belong to an outstanding set.
  a_sets_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SPSHI || phase_q == PH_SPSLO || phase_q == PH_SPSPAY ||
     phase_q == PH_PPSHI || phase_q == PH_PPSLO || phase_q == PH_PPSPAY)
    |-> sets_left_q != 8'd0)
    else $error("set phase with no sets left");

  // A truncated status is only ever reported on a final byte.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_TRUNCATED |-> out_data_o.record_done)
    else $error("truncated status without record end");

  // The header position never runs past the length size byte.
  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= HeaderLastPos)
    else $error("header position out of range");
`endif

endmodule

// File: tb/sv/avc_config_record_parser_tb.sv
module avc_config_record_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avccrp_pkg::*;

  // Run length and stop limit.
  localparam int RandomItems = 1350;
  localparam int CycleLimit  = 400000;
  localparam int TailCycles  = 8;

  // Idle probabilities in percent.
  localparam int IdlePctHigh = 58;
  localparam int IdlePctLow  = 8;

  // Hand-picked records: the shortest complete record with extreme header
  // bytes, a record with one SPS, an empty and a filled PPS and a trailing
  // byte, and a record cut short after its first byte.
  localparam logic [7*8-1:0] MinRecord =
    {8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hE0, 8'h00};
  localparam logic [16*8-1:0] MixedRecord =
    {8'h01, 8'h42, 8'h00, 8'h1E, 8'hFC, 8'hE1, 8'h00, 8'h01,
     8'h67, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hAA};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Tracks the parse state of the record stream and holds the tagged bytes
  // that the block still owes.
  class record_scoreboard;
    phase_e      ph;
    logic [2:0]  hdr_pos;
    logic [7:0]  sets_left;
    logic [7:0]  cur_set;
    logic [7:0]  len_hi;
    logic [15:0] pay_left;
    logic [7:0]  version;
    logic [7:0]  profile;
    logic [7:0]  compat;
    logic [7:0]  level;
    logic [1:0]  size_m1;
    out_t        tagged_q[$];
    int          mismatches;
    int          results_seen;

    function new();
      rearm();
      version = '0;
      profile = '0;
      compat = '0;
      level = '0;
      size_m1 = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    // Parse state goes back to the start; captured header values stay.
    function void rearm();
      ph = PH_HEADER;
      hdr_pos = '0;
      sets_left = '0;
      cur_set = '0;
      len_hi = '0;
      pay_left = '0;
    endfunction

    // One parameter set has ended: step to the next set or the next kind.
    function void close_set(bit pps);
      sets_left = sets_left - 8'd1;
      cur_set = cur_set + 8'd1;
      if (sets_left == '0) begin
        if (pps) ph = PH_DONE;
        else ph = PH_PPSCOUNT;
      end else begin
        if (pps) ph = PH_PPSHI;
        else ph = PH_SPSHI;
      end
    endfunction

    // Works out the tagged byte for one accepted input transaction.
    function void note_byte(in_t item);
      out_t       want;
      bit         pps;
      logic [7:0] b;
      b = item.data_byte;
      want = '0;
      want.byte_value = b;
      want.role = ROLE_TRAILING;
      case (ph)
        PH_HEADER: begin
          want.role = ROLE_HEADER;
          case (hdr_pos)
            3'd0: version = b;
            3'd1: profile = b;
            3'd2: compat = b;
            3'd3: level = b;
            default: size_m1 = b[1:0];
          endcase
          if (hdr_pos >= HeaderLastPos) begin
            hdr_pos = '0;
            ph = PH_SPSCOUNT;
          end else begin
            hdr_pos = hdr_pos + 3'd1;
          end
        end
        PH_SPSCOUNT, PH_PPSCOUNT: begin
          pps = (ph == PH_PPSCOUNT);
          if (pps) begin
            want.role = ROLE_PPSCOUNT;
            sets_left = b;
          end else begin
            want.role = ROLE_SPSCOUNT;
            sets_left = b & SpsCountMask;
          end
          cur_set = '0;
          if (sets_left == '0) begin
            if (pps) ph = PH_DONE;
            else ph = PH_PPSCOUNT;
          end else begin
            if (pps) ph = PH_PPSHI;
            else ph = PH_SPSHI;
          end
        end
        PH_SPSHI, PH_PPSHI: begin
          want.role = ROLE_LENGTH;
          want.set_index = cur_set;
          len_hi = b;
          if (ph == PH_PPSHI) ph = PH_PPSLO;
          else ph = PH_SPSLO;
        end
        PH_SPSLO, PH_PPSLO: begin
          pps = (ph == PH_PPSLO);
          want.role = ROLE_LENGTH;
          want.set_index = cur_set;
          pay_left = {len_hi, b};
          if (pay_left == '0) begin
            // An empty set ends on its low length byte.
            want.set_end = 1'b1;
            close_set(pps);
          end else begin
            if (pps) ph = PH_PPSPAY;
            else ph = PH_SPSPAY;
          end
        end
        PH_SPSPAY, PH_PPSPAY: begin
          pps = (ph == PH_PPSPAY);
          if (pps) want.role = ROLE_PPSPAY;
          else want.role = ROLE_SPSPAY;
          want.set_index = cur_set;
          pay_left = pay_left - 16'd1;
          if (pay_left == '0) begin
            want.set_end = 1'b1;
            close_set(pps);
          end
        end
        default: begin
          // Bytes after a complete record are only tagged as trailing.
        end
      endcase
      want.record_done = item.last_byte;
      if (item.last_byte && ph != PH_DONE) want.status = STATUS_TRUNCATED;
      else want.status = STATUS_COMPLETE;
      want.version = version;
      want.profile = profile;
      want.compatibility = compat;
      want.level = level;
      want.length_size_minus_one = size_m1;
      tagged_q.insert(tagged_q.size(), want);
      if (item.last_byte) rearm();
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string msg);
      $display("MISMATCH at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    // Compares one output transaction with the oldest outstanding byte.
    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (tagged_q.size() == 0) begin
        report_mismatch("output transaction with no byte outstanding");
        return;
      end
      want = tagged_q.pop_front();
      compare_field("byte_value", got.byte_value, want.byte_value);
      compare_field("role", 8'(got.role), 8'(want.role));
      compare_field("set_index", got.set_index, want.set_index);
      compare_field("set_end", 8'(got.set_end), 8'(want.set_end));
      compare_field("record_done", 8'(got.record_done), 8'(want.record_done));
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("version", got.version, want.version);
      compare_field("profile", got.profile, want.profile);
      compare_field("compatibility", got.compatibility, want.compatibility);
      compare_field("level", got.level, want.level);
      compare_field("length_size_minus_one", 8'(got.length_size_minus_one),
                    8'(want.length_size_minus_one));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  record_scoreboard sb = new();
  idle_mode_e idle_mode = IDLE_NONE;
  logic [7:0] record_q[$];
  int items_sent = 0;
  int cycle_count = 0;

  avc_config_record_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure according to the current idle mode.
  always @(posedge clk_i) begin
    if (idle_mode == IDLE_RECEIVER) out_ready_i <= ($urandom_range(99) >= IdlePctHigh);
    else if (idle_mode == IDLE_BOTH) out_ready_i <= ($urandom_range(99) >= IdlePctLow);
    else out_ready_i <= 1'b1;
  end

  // Monitor both channels and stop a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int sender_idle_pct();
    if (idle_mode == IDLE_SENDER) return IdlePctHigh;
    if (idle_mode == IDLE_BOTH) return IdlePctLow;
    return 0;
  endfunction

  // Offers one byte, with random idle cycles ahead of it, and returns at the
  // edge where the transaction is accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_t item;
    item.data_byte = b;
    item.last_byte = last;
    if ($urandom_range(99) < sender_idle_pct()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct());
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Sends the bytes of record_q, flagging the final one.
  task automatic send_record();
    foreach (record_q[i]) send_byte(record_q[i], i == record_q.size() - 1);
  endtask

  task automatic load_bytes(input logic [255:0] v, input int n);
    record_q.delete();
    for (int i = 0; i < n; i++) record_q.insert(record_q.size(), v[8*(n-1-i) +: 8]);
  endtask

  // Holds the input channel idle until every byte has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.tagged_q.size() != 0);
  endtask

  // Set count: mostly a few sets, sometimes none, now and then many.
  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 31);
  endfunction

  // Appends n sets; wide sets take any 16-bit length and are capped in size,
  // since such records are only ever sent cut short.
  task automatic add_sets(input int n, input bit wide);
    int len;
    int cap;
    int r;
    cap = wide ? 400 : 1000000;
    for (int s = 0; s < n && record_q.size() < cap; s++) begin
      r = $urandom_range(999);
      if (wide) len = $urandom_range(65535);
      else if (r < 150) len = 0;
      else if (r < 995) len = $urandom_range(1, 8);
      else len = $urandom_range(256, 270);
      record_q.insert(record_q.size(), len[15:8]);
      record_q.insert(record_q.size(), len[7:0]);
      for (int k = 0; k < len && record_q.size() < cap; k++)
        record_q.insert(record_q.size(), 8'($urandom));
    end
  endtask

  // Builds a whole record with random header, counts and payload bytes.
  task automatic build_record(input bit wide);
    logic [7:0] cnt;
    record_q.delete();
    repeat (5) record_q.insert(record_q.size(), 8'($urandom));
    if (wide) cnt = 8'($urandom);
    else cnt = {3'($urandom), 5'(pick_count())};
    record_q.insert(record_q.size(), cnt);
    add_sets(int'(cnt & SpsCountMask), wide);
    if (wide) cnt = 8'($urandom);
    else cnt = 8'(pick_count());
    record_q.insert(record_q.size(), cnt);
    add_sets(int'(cnt), wide);
  endtask

  initial begin
    int rand_base;
    int r;
    int cut;
    idle_mode_e modes[4];
    modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked records first.
    load_bytes(256'(MinRecord), 7);
    send_record();
    load_bytes(256'(MixedRecord), 16);
    send_record();
    send_byte(8'h00, 1'b1);

    // Random records, one idle mode per quarter; the sender waits for the
    // block to drain between quarters.
    rand_base = items_sent;
    for (int p = 0; p < 4; p++) begin
      idle_mode = modes[p];
      while (items_sent - rand_base < RandomItems * (p + 1) / 4) begin
        r = $urandom_range(99);
        if (r < 68) begin
          // Well-formed, sometimes with trailing bytes.
          build_record(1'b0);
          if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) record_q.insert(record_q.size(), 8'($urandom));
        end else if (r < 93) begin
          // Cut short somewhere inside the record.
          build_record(1'($urandom_range(1)));
          cut = $urandom_range(1, (record_q.size() - 1 < 60) ? record_q.size() - 1 : 60);
          record_q = record_q[0:cut-1];
        end else begin
          // Random bytes.
          record_q.delete();
          repeat ($urandom_range(1, 12)) record_q.insert(record_q.size(), 8'($urandom));
        end
        send_record();
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.tagged_q.size() != 0)
      sb.report_mismatch($sformatf("%0d bytes never came out", sb.tagged_q.size()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
